FILE: rtl/core/assert_macros.svh
// Assertion helpers shared by the deque RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that an expression holds on every clock outside reset.
`define ASSERT_ALWAYS(name, ck, rn, expr, msg) \
    name: assert property (@(posedge ck) disable iff (!rn) (expr)) \
        else $error(msg);

// Check that a condition implies another one on the next clock.
`define ASSERT_NEXT(name, ck, rn, ante, cons, msg) \
    name: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/dq_pkg.sv
package dq_pkg;

    typedef enum logic [2:0] {
        CMD_PUSH_FRONT = 3'd0,
        CMD_PUSH_BACK  = 3'd1,
        CMD_POP_FRONT  = 3'd2,
        CMD_POP_BACK   = 3'd3,
        CMD_SIZE       = 3'd4,
        CMD_EMPTY      = 3'd5,
        CMD_FRONT      = 3'd6,
        CMD_BACK       = 3'd7
    } dq_cmd_t;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_FULL  = 2'd2
    } dq_status_t;

    typedef struct packed {
        dq_cmd_t     command;
        logic [31:0] push_value;
    } dq_req_t;

    typedef struct packed {
        logic [31:0] result_value;
        dq_status_t  status;
    } dq_rsp_t;

    // Control passed from the pointer stage to the result stage
    typedef struct packed {
        logic        valid;
        logic        use_mem;
        dq_status_t  status;
        logic [31:0] value;
    } dq_stage_t;

endpackage

FILE: rtl/core/dq_ram.sv
module dq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write one word, read one word with registered output
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: rtl/core/dq_ctrl.sv
`include "assert_macros.svh"

module dq_ctrl #(
    parameter int DEPTH      = 1024,
    parameter int DATA_WIDTH = 32
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  dq_pkg::dq_req_t          request,
    output logic                     wr_en,
    output logic [$clog2(DEPTH)-1:0] wr_addr,
    output logic [DATA_WIDTH-1:0]    wr_data,
    output logic                     rd_en,
    output logic [$clog2(DEPTH)-1:0] rd_addr,
    output dq_pkg::dq_stage_t        stage
);

    import dq_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic            in_valid_reg;
    dq_req_t         in_req_reg;
    logic [AW-1:0]   head_reg, head_next;
    logic [CW-1:0]   count_reg, count_next;
    dq_stage_t       stage_reg, stage_next;

    logic            is_empty;
    logic            is_full;
    logic [AW-1:0]   head_inc;
    logic [AW-1:0]   head_dec;
    logic [AW:0]     back_sum;
    logic [AW:0]     tail_sum;
    logic [AW-1:0]   back_slot;
    logic [AW-1:0]   tail_slot;

    // Ring pointer arithmetic
    always_comb
    begin
        is_empty  = (count_reg == '0);
        is_full   = (count_reg == CW'(DEPTH));
        head_inc  = (head_reg == AW'(DEPTH - 1)) ? '0 : head_reg + 1'b1;
        head_dec  = (head_reg == '0) ? AW'(DEPTH - 1) : head_reg - 1'b1;
        back_sum  = (AW + 1)'(head_reg) + (AW + 1)'(count_reg);
        tail_sum  = back_sum - 1'b1;
        back_slot = (back_sum >= (AW + 1)'(DEPTH)) ?
                    AW'(back_sum - (AW + 1)'(DEPTH)) : AW'(back_sum);
        tail_slot = (tail_sum >= (AW + 1)'(DEPTH)) ?
                    AW'(tail_sum - (AW + 1)'(DEPTH)) : AW'(tail_sum);
    end

    // Decode the held request into memory access and pointer update
    always_comb
    begin
        head_next  = head_reg;
        count_next = count_reg;
        wr_en      = 1'b0;
        wr_addr    = head_dec;
        wr_data    = DATA_WIDTH'(in_req_reg.push_value);
        rd_en      = 1'b0;
        rd_addr    = head_reg;
        stage_next = '{valid: in_valid_reg, use_mem: 1'b0,
                       status: STAT_OK, value: '0};
        if (in_valid_reg)
        begin
            case (in_req_reg.command)
                CMD_PUSH_FRONT:
                begin
                    stage_next.valid = is_full;
                    if (is_full)
                    begin
                        stage_next.status = STAT_FULL;
                    end
                    else
                    begin
                        wr_en      = 1'b1;
                        wr_addr    = head_dec;
                        head_next  = head_dec;
                        count_next = count_reg + 1'b1;
                    end
                end
                CMD_PUSH_BACK:
                begin
                    stage_next.valid = is_full;
                    if (is_full)
                    begin
                        stage_next.status = STAT_FULL;
                    end
                    else
                    begin
                        wr_en      = 1'b1;
                        wr_addr    = back_slot;
                        count_next = count_reg + 1'b1;
                    end
                end
                CMD_POP_FRONT:
                begin
                    if (is_empty)
                    begin
                        stage_next.status = STAT_EMPTY;
                    end
                    else
                    begin
                        rd_en              = 1'b1;
                        rd_addr            = head_reg;
                        stage_next.use_mem = 1'b1;
                        head_next          = head_inc;
                        count_next         = count_reg - 1'b1;
                    end
                end
                CMD_POP_BACK:
                begin
                    if (is_empty)
                    begin
                        stage_next.status = STAT_EMPTY;
                    end
                    else
                    begin
                        rd_en              = 1'b1;
                        rd_addr            = tail_slot;
                        stage_next.use_mem = 1'b1;
                        count_next         = count_reg - 1'b1;
                    end
                end
                CMD_SIZE:
                begin
                    stage_next.value = 32'(count_reg);
                end
                CMD_EMPTY:
                begin
                    stage_next.value = 32'(is_empty);
                end
                CMD_FRONT:
                begin
                    if (is_empty)
                    begin
                        stage_next.status = STAT_EMPTY;
                    end
                    else
                    begin
                        rd_en              = 1'b1;
                        rd_addr            = head_reg;
                        stage_next.use_mem = 1'b1;
                    end
                end
                CMD_BACK:
                begin
                    if (is_empty)
                    begin
                        stage_next.status = STAT_EMPTY;
                    end
                    else
                    begin
                        rd_en              = 1'b1;
                        rd_addr            = tail_slot;
                        stage_next.use_mem = 1'b1;
                    end
                end
                default:
                begin
                    stage_next.valid = 1'b0;
                end
            endcase
        end
    end

    // Capture the request, advance pointers, hold stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            head_reg     <= '0;
            count_reg    <= '0;
            stage_reg    <= '0;
        end
        else
        begin
            in_valid_reg <= start;
            head_reg     <= head_next;
            count_reg    <= count_next;
            stage_reg    <= stage_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            in_req_reg <= request;
        end
    end

    assign stage = stage_reg;

    `ASSERT_ALWAYS(a_count_bound, clk, rst_n, count_reg <= CW'(DEPTH),
        "entry count above depth")
    `ASSERT_ALWAYS(a_one_access, clk, rst_n, !(wr_en && rd_en),
        "memory read and write in one cycle")
    `ASSERT_NEXT(a_push_grows, clk, rst_n,
        in_valid_reg && !is_full && (in_req_reg.command == CMD_PUSH_FRONT ||
        in_req_reg.command == CMD_PUSH_BACK),
        count_reg == CW'($past(count_reg) + 1'b1),
        "accepted push did not grow the count")

endmodule

FILE: rtl/core/dq_out.sv
`include "assert_macros.svh"

module dq_out #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  dq_pkg::dq_stage_t     stage,
    input  logic [DATA_WIDTH-1:0] rd_data,
    output dq_pkg::dq_rsp_t       response,
    output logic                  response_valid
);

    import dq_pkg::*;

    logic    valid_reg;
    dq_rsp_t rsp_reg, rsp_next;

    // Pick memory word or computed value
    always_comb
    begin
        rsp_next.result_value = stage.use_mem ? 32'(rd_data) : stage.value;
        rsp_next.status       = stage.status;
    end

    // Hold the result for one strobe cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            rsp_reg   <= '0;
        end
        else
        begin
            valid_reg <= stage.valid;
            rsp_reg   <= rsp_next;
        end
    end

    assign response       = rsp_reg;
    assign response_valid = valid_reg;

    `ASSERT_NEXT(a_mem_ok, clk, rst_n, stage.valid && stage.use_mem,
        response_valid && response.status == STAT_OK,
        "memory result lost or flagged")

endmodule

FILE: rtl/core/double_ended_queue.sv
// Double-ended queue over a circular buffer in one RAM.
// Results pass the request, stage and output registers; accepted pushes return none.
// Throughput: one request per cycle; busy stays low, set by one RAM access per request.
// The receiver cannot stall; each result is shown for exactly one cycle.
// Reset clears head and count at once; RAM contents stay undefined until written.
module double_ended_queue #(
    parameter int DEPTH      = 1024,
    parameter int DATA_WIDTH = 32
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    input  dq_pkg::dq_req_t request,
    output dq_pkg::dq_rsp_t response,
    output logic            response_valid
);

    import dq_pkg::*;

    localparam int AW = $clog2(DEPTH);

    logic                  wr_en;
    logic [AW-1:0]         wr_addr;
    logic [DATA_WIDTH-1:0] wr_data;
    logic                  rd_en;
    logic [AW-1:0]         rd_addr;
    logic [DATA_WIDTH-1:0] rd_data;
    dq_stage_t             stage;

    // Take a request every cycle
    assign busy = 1'b0;

    dq_ctrl #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .request (request),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .stage   (stage)
    );

    dq_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    dq_out #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_out (
        .clk            (clk),
        .rst_n          (rst_n),
        .stage          (stage),
        .rd_data        (rd_data),
        .response       (response),
        .response_valid (response_valid)
    );

endmodule
